// File: design/quad_encoder_io_register_block_defines.svh
// Assertion macros for the quadrature encoder I/O register block.
// Used by the port checker; no other dependencies.
`ifndef QUAD_ENCODER_IO_REGISTER_BLOCK_DEFINES_SVH
`define QUAD_ENCODER_IO_REGISTER_BLOCK_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define QEIO_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define QEIO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/qeio_pkg.sv
// Shared types and constants for the quadrature encoder I/O register block.
// Used by the core and the top level; no dependencies.
package qeio_pkg;

  // Encoder count limits
  localparam int ENC_NUM_DEF  = 4;
  localparam logic [7:0] COUNT_MAX = 8'd255;
  localparam logic [7:0] COUNT_MIN = 8'd0;

  // Item kinds carried on the input tuser
  localparam logic [1:0] KIND_SAMPLE   = 2'd0;
  localparam logic [1:0] KIND_COMMAND  = 2'd1;
  localparam logic [1:0] KIND_TRANSMIT = 2'd2;

  // Command byte decoding
  localparam logic [3:0] CMD_LO_CLEAR    = 4'h0;
  localparam logic [3:0] CMD_LO_READ     = 4'h1;
  localparam logic [7:0] CMD_READ_SWITCH = 8'h40;
  localparam logic [7:0] CMD_READ_BUTTON = 8'h50;
  localparam logic [3:0] CMD_HI_LED      = 4'h8;

  // Configuration registers
  localparam int          PADDR_W          = 3;
  localparam logic        REG_REVERSE_MASK = 1'b0;
  localparam logic [3:0]  REVERSE_MASK_RST = 4'h1;

  // Input beat payload, first field in the highest bits
  typedef struct packed {
    logic [7:0] rx_byte;
    logic [3:0] switch_pins;
    logic [3:0] button_pins;
    logic [3:0] enc_b;
    logic [3:0] enc_a;
  } item_t;

  // Result of one item
  typedef struct packed {
    logic [3:0] led_state;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } result_t;

endpackage

// File: design/qeio_core.sv
// Encoder counters, button latches, transmit and LED registers with their update logic.
// Depends on qeio_pkg.
module qeio_core
  import qeio_pkg::*;
#(
  parameter int NUM_ENCODERS = ENC_NUM_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [1:0] kind,
  input  item_t      item,
  input  logic [3:0] reverse_mask,
  output result_t    result
);

  localparam logic [3:0] ENC_MASK = 4'((1 << NUM_ENCODERS) - 1);

  logic [7:0]              enc_count      [NUM_ENCODERS];
  logic [7:0]              enc_count_next [NUM_ENCODERS];
  logic [NUM_ENCODERS-1:0] last_a, last_a_next;
  logic                    primed, primed_next;
  logic [3:0]              button_latch, button_latch_next;
  logic [7:0]              tx_hold, tx_hold_next;
  logic [3:0]              led_hold, led_hold_next;

  logic [3:0] cmd_hi, cmd_lo;
  logic [7:0] sel_count;
  logic       hi_is_enc;

  assign cmd_hi    = item.rx_byte[7:4];
  assign cmd_lo    = item.rx_byte[3:0];
  assign hi_is_enc = (cmd_hi < 4'(NUM_ENCODERS));

  // Pick the counter addressed by the command's high nibble
  always_comb begin
    sel_count = '0;
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      if (cmd_hi == 4'(i)) begin
        sel_count = enc_count[i];
      end
    end
  end

  // Next state and result for one item
  always_comb begin
    logic ai, bi, up;
    ai = 1'b0;
    bi = 1'b0;
    up = 1'b0;
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      enc_count_next[i] = enc_count[i];
    end
    last_a_next       = last_a;
    primed_next       = primed;
    button_latch_next = button_latch;
    tx_hold_next      = tx_hold;
    led_hold_next     = led_hold;
    result.tx_valid   = 1'b0;
    result.tx_byte    = '0;

    unique case (kind)
      KIND_SAMPLE: begin
        for (int i = 0; i < NUM_ENCODERS; i++) begin
          ai = item.enc_a[i];
          bi = item.enc_b[i];
          up = reverse_mask[i] ? (ai == bi) : (ai != bi);
          if (primed && (ai != last_a[i])) begin
            if (up) begin
              if (enc_count[i] != COUNT_MAX) enc_count_next[i] = enc_count[i] + 8'd1;
            end else begin
              if (enc_count[i] != COUNT_MIN) enc_count_next[i] = enc_count[i] - 8'd1;
            end
          end
        end
        last_a_next       = item.enc_a[NUM_ENCODERS-1:0];
        primed_next       = 1'b1;
        button_latch_next = button_latch | (item.button_pins & ENC_MASK);
      end
      KIND_COMMAND: begin
        priority if (hi_is_enc) begin
          if (cmd_lo == CMD_LO_CLEAR) begin
            for (int i = 0; i < NUM_ENCODERS; i++) begin
              if (cmd_hi == 4'(i)) enc_count_next[i] = '0;
            end
            tx_hold_next = '0;
          end else if (cmd_lo == CMD_LO_READ) begin
            tx_hold_next = sel_count;
          end
        end else if (item.rx_byte == CMD_READ_SWITCH) begin
          tx_hold_next = {4'h0, item.switch_pins};
        end else if (item.rx_byte == CMD_READ_BUTTON) begin
          tx_hold_next      = {4'h0, button_latch};
          button_latch_next = '0;
        end else if (cmd_hi == CMD_HI_LED) begin
          led_hold_next = cmd_lo;
        end else begin
          // unknown command byte: nothing changes
        end
      end
      KIND_TRANSMIT: begin
        result.tx_valid = 1'b1;
        result.tx_byte  = tx_hold;
        tx_hold_next    = '0;
      end
      default: begin
        // unused kind: nothing changes
      end
    endcase
    result.led_state = led_hold_next;
  end

  // Commit state when an item is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        enc_count[i] <= '0;
      end
      last_a       <= '0;
      primed       <= 1'b0;
      button_latch <= '0;
      tx_hold      <= '0;
      led_hold     <= '0;
    end else if (fire) begin
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        enc_count[i] <= enc_count_next[i];
      end
      last_a       <= last_a_next;
      primed       <= primed_next;
      button_latch <= button_latch_next;
      tx_hold      <= tx_hold_next;
      led_hold     <= led_hold_next;
    end
  end

endmodule

// File: design/quad_encoder_io_register_block.sv
// Quadrature encoder I/O register block: input register, core update, result register.
// An accepted beat passes the input register, then the result register, and is presented from there.
// Throughput: one item per clock while the result stream does not stall it through m_axis_tready.
// Reset (synchronous, rst high): counters, latches, transmit and LED registers clear,
// the first pin sample only primes the last-A levels, reverse_mask returns to 1.
module quad_encoder_io_register_block
  import qeio_pkg::*;
#(
  parameter int NUM_ENCODERS = ENC_NUM_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,  // enc_a[3:0], enc_b[7:4], button_pins[11:8],
                                            // switch_pins[15:12], rx_byte[23:16]
  input  logic [1:0]         s_axis_tuser,  // cmd[1:0]
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,  // tx_byte[7:0], led_state[11:8], zero[15:12]
  output logic               m_axis_tuser,  // tx_valid[0]
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic       in_valid;
  item_t      in_item;
  logic [1:0] in_kind;
  logic       out_valid;
  result_t    out_result;
  result_t    core_result;
  logic       advance;
  logic       fire;
  logic [3:0] reverse_mask;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_REVERSE_MASK) ? {28'h0, reverse_mask} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_mask <= REVERSE_MASK_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[PADDR_W-1:2] == REG_REVERSE_MASK)) begin
      reverse_mask <= pwdata[3:0];
    end
  end

  // Pipeline handshake: result register frees when taken, input stage moves into it
  assign advance       = !out_valid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= item_t'(s_axis_tdata);
      in_kind <= s_axis_tuser;
    end
  end

  qeio_core #(
    .NUM_ENCODERS (NUM_ENCODERS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .kind         (in_kind),
    .item         (in_item),
    .reverse_mask (reverse_mask),
    .result       (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= core_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'h0, out_result.led_state, out_result.tx_byte};
  assign m_axis_tuser  = out_result.tx_valid;

endmodule

// File: design/qeio_checker.sv
// Port-level checker for the quadrature encoder I/O register block, bound to the top level.
// Depends on quad_encoder_io_register_block_defines.svh.
`include "quad_encoder_io_register_block_defines.svh"

module qeio_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // Hold a stalled result beat
  `QEIO_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `QEIO_ASSERT_NEXT(a_out_stable, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // Only a transmit answer carries a nonzero byte
  `QEIO_ASSERT_IMPLY(a_tx_zero, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[7:0] == 8'h00)

  // No result beat right after reset
  `QEIO_ASSERT_IMPLY(a_reset_empty, clk, rst, $past(rst), !m_axis_tvalid)

endmodule

bind quad_encoder_io_register_block qeio_checker u_checker (.*);
